@@ rtl/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Types and codes shared by the FIFO queue with search unit: operation and
// status codes, sequencer states, and the command and result transfers.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_VIEW   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    op_t                     kind;
    status_t                 status;
    logic signed [DataW-1:0] element;
    logic [CountW-1:0]       match_count;
    logic                    found;
    logic                    last;
  } result_t;

endpackage

@@ rtl/fifo_queue_with_search_unit.sv @@
// Insert, delete and any command on an empty store: the result is registered from the
// transfer itself; busy stays low, so one such command can be taken every cycle.
// Search and view: busy through the scan and drain states while the one memory read port
// walks the ring an entry per cycle; each entry passes the read data register and then the
// result register: view results follow one per cycle, and the search result follows the last.
// Synchronous reset empties the store (head, tail, occupancy); entries keep their contents.
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// Bounded ring FIFO of signed 32-bit words with insert, delete head, search
// by key (match count) and view (stream from head to tail).
// ----------------------------------------------------------------------------
module fifo_queue_with_search_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fqs_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             strobe,
  output fqs_pkg::result_t result
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OccW = $clog2(DEPTH + 1);

  logic signed [fqs_pkg::DataW-1:0] mem [DEPTH];

  fqs_pkg::state_t   state, state_next;
  logic [IdxW-1:0]   head, head_next;
  logic [IdxW-1:0]   tail, tail_next;
  logic [OccW-1:0]   occupancy, occupancy_next;
  logic              strobe_next;
  fqs_pkg::result_t  result_next;

  fqs_pkg::op_t                     op_q;
  logic signed [fqs_pkg::DataW-1:0] key_q;
  logic [IdxW-1:0]                  rd_ptr;
  logic [OccW-1:0]                  remaining;
  logic [OccW-1:0]                  count, count_next;
  logic signed [fqs_pkg::DataW-1:0] rd_data;
  logic                             rd_vld, rd_vld_next;
  logic                             rd_last;

  logic accept;
  logic is_full;
  logic is_empty;
  logic write_en;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    wrap_inc = (p == IdxW'(DEPTH - 1)) ? '0 : p + IdxW'(1);
  endfunction

  assign busy     = (state != fqs_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (occupancy == OccW'(DEPTH));
  assign is_empty = (occupancy == '0);

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    strobe_next    = 1'b0;
    write_en       = 1'b0;
    rd_vld_next    = 1'b0;
    count_next     = count + OccW'(rd_data == key_q);
    result_next    = '0;
    result_next.kind   = op_q;
    result_next.status = fqs_pkg::ST_OK;

    if (accept) begin
      result_next.kind = cmd.operation;
      result_next.last = 1'b1;
      case (cmd.operation)
        fqs_pkg::OP_INSERT: begin
          strobe_next = 1'b1;
          if (is_full) begin
            result_next.status = fqs_pkg::ST_FULL;
          end else begin
            write_en       = 1'b1;
            tail_next      = wrap_inc(tail);
            occupancy_next = occupancy + OccW'(1);
          end
        end
        fqs_pkg::OP_DELETE: begin
          strobe_next = 1'b1;
          if (is_empty) begin
            result_next.status = fqs_pkg::ST_EMPTY;
          end else begin
            head_next      = wrap_inc(head);
            occupancy_next = occupancy - OccW'(1);
          end
        end
        fqs_pkg::OP_SEARCH, fqs_pkg::OP_VIEW: begin
          if (is_empty) begin
            strobe_next        = 1'b1;
            result_next.status = fqs_pkg::ST_EMPTY;
          end else begin
            state_next = fqs_pkg::S_SCAN;
          end
        end
        default: begin
          strobe_next = 1'b1;
        end
      endcase
    end

    case (state)
      fqs_pkg::S_SCAN: begin
        rd_vld_next = 1'b1;
        if (remaining == OccW'(1)) begin
          state_next = fqs_pkg::S_DRAIN;
        end
      end
      fqs_pkg::S_DRAIN: begin
        if (rd_vld && rd_last) begin
          state_next = fqs_pkg::S_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (rd_vld) begin
      if (op_q == fqs_pkg::OP_VIEW) begin
        strobe_next         = 1'b1;
        result_next.element = rd_data;
        result_next.last    = rd_last;
      end else if (rd_last) begin
        strobe_next             = 1'b1;
        result_next.match_count = fqs_pkg::CountW'(count_next);
        result_next.found       = (count_next != '0);
        result_next.last        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fqs_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      strobe    <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      occupancy <= occupancy_next;
      strobe    <= strobe_next;
      rd_vld    <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      op_q      <= cmd.operation;
      key_q     <= cmd.value;
      rd_ptr    <= head;
      remaining <= occupancy;
      count     <= '0;
    end else begin
      if (state == fqs_pkg::S_SCAN) begin
        rd_ptr    <= wrap_inc(rd_ptr);
        remaining <= remaining - OccW'(1);
        rd_last   <= (remaining == OccW'(1));
      end
      if (rd_vld) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[tail] <= cmd.value;
    end
    rd_data <= mem[rd_ptr];
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OccW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_tail_consistent: assert property (@(posedge clk) disable iff (rst)
    ((32'(head) + 32'(occupancy) >= 32'(DEPTH)) ?
       (32'(tail) == 32'(head) + 32'(occupancy) - 32'(DEPTH)) :
       (32'(tail) == 32'(head) + 32'(occupancy))))
    else $error("tail pointer out of step with head and occupancy");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_empty &&
     (cmd.operation == fqs_pkg::OP_SEARCH || cmd.operation == fqs_pkg::OP_VIEW))
    |=> busy)
    else $error("search or view did not start a walk");

  a_store_frozen: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> ($stable(head) && $stable(occupancy)))
    else $error("store changed during a walk");

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == fqs_pkg::S_IDLE) |=> !rd_vld)
    else $error("read data valid outside a walk");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO queue with search unit. A scoreboard keeps
// its own copy of the ring and predicts every result of each command that is
// transferred. Results are compared field by field in order of arrival. A
// short directed run covers the empty and full cases and the value extremes.
// Random traffic then fills and drains the ring with gaps on the command side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 16;
  localparam logic signed [fqs_pkg::DataW-1:0] UNIFORM_KEY = 32'sh5A5A_C3C3;

  class fifo_search_scoreboard;
    logic signed [fqs_pkg::DataW-1:0] store [QDEPTH];
    int unsigned        head = 0;
    int unsigned        level = 0;
    fqs_pkg::result_t   awaited [$];
    int unsigned        errors = 0;
    int unsigned        accepted = 0;
    int unsigned        checked = 0;
    int unsigned        refused = 0;
    int unsigned        on_empty = 0;
    int unsigned        peak_matches = 0;

    function logic signed [fqs_pkg::DataW-1:0] entry_at(int unsigned i);
      return store[(head + i) % QDEPTH];
    endfunction

    function void note(fqs_pkg::cmd_t c);
      fqs_pkg::result_t r;
      int unsigned      hits;
      r = '0;
      r.kind = c.operation;
      r.status = fqs_pkg::ST_OK;
      r.last = 1'b1;
      accepted++;
      if (c.operation == fqs_pkg::OP_INSERT) begin
        if (level >= QDEPTH) begin
          r.status = fqs_pkg::ST_FULL;
          refused++;
        end else begin
          store[(head + level) % QDEPTH] = c.value;
          level++;
        end
        awaited.push_back(r);
      end else if (level == 0) begin
        r.status = fqs_pkg::ST_EMPTY;
        on_empty++;
        awaited.push_back(r);
      end else if (c.operation == fqs_pkg::OP_DELETE) begin
        head = (head + 1) % QDEPTH;
        level--;
        awaited.push_back(r);
      end else if (c.operation == fqs_pkg::OP_SEARCH) begin
        hits = 0;
        for (int unsigned i = 0; i < level; i++) begin
          if (entry_at(i) == c.value) hits++;
        end
        r.match_count = hits[fqs_pkg::CountW-1:0];
        r.found = (hits != 0);
        if (hits > peak_matches) peak_matches = hits;
        awaited.push_back(r);
      end else begin
        for (int unsigned i = 0; i < level; i++) begin
          r.element = entry_at(i);
          r.last = (i + 1 == level);
          awaited.push_back(r);
        end
      end
    endfunction

    function void field_diff(string name, logic [fqs_pkg::DataW-1:0] want,
                             logic [fqs_pkg::DataW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check(fqs_pkg::result_t got);
      fqs_pkg::result_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
        return;
      end
      want = awaited.pop_front();
      field_diff("kind", fqs_pkg::DataW'(want.kind), fqs_pkg::DataW'(got.kind));
      field_diff("status", fqs_pkg::DataW'(want.status), fqs_pkg::DataW'(got.status));
      field_diff("element", want.element, got.element);
      field_diff("match_count", fqs_pkg::DataW'(want.match_count),
                 fqs_pkg::DataW'(got.match_count));
      field_diff("found", fqs_pkg::DataW'(want.found), fqs_pkg::DataW'(got.found));
      field_diff("last", fqs_pkg::DataW'(want.last), fqs_pkg::DataW'(got.last));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  fqs_pkg::cmd_t    cmd;
  logic             busy;
  logic             strobe;
  fqs_pkg::result_t result;

  fifo_search_scoreboard sb;

  logic draining = 1'b0;
  logic uniform = 1'b0;
  logic signed [fqs_pkg::DataW-1:0] value_pool [6] = '{32'sh8000_0000, 32'sh7FFF_FFFF,
                                                       32'sh0, 32'shFFFF_FFFF, 32'sh1,
                                                       UNIFORM_KEY};

  fifo_queue_with_search_unit #(.DEPTH(QDEPTH)) dut (
    .clk,
    .rst,
    .start,
    .cmd,
    .busy,
    .strobe,
    .result
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check(result);
  end

  task automatic issue(fqs_pkg::op_t op, logic signed [fqs_pkg::DataW-1:0] v,
                       int unsigned gap_pct);
    fqs_pkg::cmd_t c;
    c.operation = op;
    c.value = v;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note(c);
  endtask

  task automatic directed_part();
    issue(fqs_pkg::OP_DELETE, 32'sh0, 0);
    issue(fqs_pkg::OP_SEARCH, 32'shFFFF_FFFF, 0);
    issue(fqs_pkg::OP_VIEW, 32'sh0, 0);
    issue(fqs_pkg::OP_INSERT, 32'sh8000_0000, 0);
    issue(fqs_pkg::OP_INSERT, 32'sh7FFF_FFFF, 0);
    issue(fqs_pkg::OP_INSERT, 32'sh0, 0);
    issue(fqs_pkg::OP_INSERT, 32'shFFFF_FFFF, 0);
    issue(fqs_pkg::OP_SEARCH, 32'sh7FFF_FFFF, 0);
    issue(fqs_pkg::OP_SEARCH, 32'sh1234_5678, 0);
    issue(fqs_pkg::OP_VIEW, 32'sh0, 0);
    for (int unsigned i = 0; i < QDEPTH - 4; i++) issue(fqs_pkg::OP_INSERT, UNIFORM_KEY, 0);
    issue(fqs_pkg::OP_INSERT, 32'sh0BAD_CAFE, 0);
    issue(fqs_pkg::OP_SEARCH, UNIFORM_KEY, 0);
    issue(fqs_pkg::OP_VIEW, 32'sh0, 0);
  endtask

  task automatic random_phase(int unsigned n, int unsigned gap_pct);
    fqs_pkg::op_t                     op;
    logic signed [fqs_pkg::DataW-1:0] v;
    int unsigned                      roll;
    for (int unsigned k = 0; k < n; k++) begin
      if (sb.level == QDEPTH) begin
        draining = 1'b1;
      end else if (sb.level == 0 && draining) begin
        draining = 1'b0;
        uniform = ($urandom_range(3) == 0);
      end
      roll = $urandom_range(99);
      if (roll < 10) op = fqs_pkg::op_t'($urandom_range(3));
      else if (roll < 70) op = draining ? fqs_pkg::OP_DELETE : fqs_pkg::OP_INSERT;
      else if (roll < 82) op = fqs_pkg::OP_SEARCH;
      else if (roll < 90) op = fqs_pkg::OP_VIEW;
      else op = draining ? fqs_pkg::OP_INSERT : fqs_pkg::OP_DELETE;
      if (op == fqs_pkg::OP_SEARCH && sb.level != 0 && $urandom_range(2) != 0)
        v = sb.entry_at($urandom_range(sb.level - 1));
      else if (uniform && roll >= 10)
        v = UNIFORM_KEY;
      else if ($urandom_range(1) == 1)
        v = value_pool[$urandom_range(5)];
      else
        v = $urandom;
      issue(op, v, gap_pct);
    end
  endtask

  initial begin
    int unsigned waited;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    random_phase(85, 28);
    random_phase(80, 65);
    random_phase(70, 0);
    start <= 1'b0;
    waited = 0;
    while (sb.awaited.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (QDEPTH + 4) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived, actual none", $time,
               sb.awaited.size());
    end
    $display("summary: %0d commands transferred, %0d results checked, %0d refused inserts",
             sb.accepted, sb.checked, sb.refused);
    $display("summary: %0d answers from an empty store, largest match count %0d",
             sb.on_empty, sb.peak_matches);
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ fifo_queue_with_search_unit.f @@
rtl/fqs_pkg.sv
rtl/fifo_queue_with_search_unit.sv
test/tb_top.sv
